### rtl/tit_pkg.sv
// ----------------------------------------------------------------------------
// tit_pkg
// Shared types and constants of the tuple intern table: table geometry,
// result status codes and the descriptor tuple layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tit_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W + 1;

  // Fixed result field widths
  localparam int ENTRY_W = 8;
  localparam int USED_W  = 9;
  localparam int ST_W    = 2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_CLS0   = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd3;

  // Item kinds
  localparam logic MODE_INTERN = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // One stored descriptor tuple (56 bits)
  typedef struct packed {
    logic [7:0]  cls;
    logic [7:0]  flg;
    logic [15:0] va;
    logic [15:0] vb;
    logic [7:0]  lnk;
  } slot_t;

  // One incoming item
  typedef struct packed {
    logic       mode;
    slot_t      tuple;
    logic [7:0] ri;
  } item_t;

  // One result toward the output register
  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [ST_W-1:0]    st;
    slot_t              slot;
    logic [USED_W-1:0]  used;
  } res_t;

endpackage

`default_nettype wire

### rtl/tuple_intern_table_top.sv
// ----------------------------------------------------------------------------
// tuple_intern_table_top
// Interning table for five-field type descriptors. Intern items return the
// index of an equal stored tuple or append it if not full; read items return an entry.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tuser = mode, s_tdata = tuple, index
//   m_*      out  m_tvalid/m_tready  m_tdata = index, status, entry, count
//
// Read item: read port, S_RDWAIT, then S_RESP; rejected items go straight to S_RESP.
// Intern item: entries from index 1 are checked up to a hit or the fill count
// by the scan that fetches one stored entry a cycle from the single read
// port and compares it the cycle after.
// Reset: synchronous; table comes up with fill count 1, no clearing pass.
// The output register holds a result under m_tready low; the next item is
// taken meanwhile but its result waits until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module tuple_intern_table_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [0:0]  s_tuser,   // [0] mode
  input  wire  [63:0] s_tdata,   // class_id, flag_bits, first_variant,
                                 // second_variant, link_in, read_index
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [79:0] m_tdata    // entry_index, status, class_out, flags_out,
                                 // first_variant_out, second_variant_out,
                                 // link_out, used_count, zero pad
);
  import tit_pkg::*;

  item_t            in_item;
  res_t             res;
  logic             res_vld;
  logic             res_take;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  slot_t            rd_data;

  // Unpack the input transfer
  assign in_item.mode      = s_tuser[0];
  assign in_item.tuple.cls = s_tdata[7:0];
  assign in_item.tuple.flg = s_tdata[15:8];
  assign in_item.tuple.va  = s_tdata[31:16];
  assign in_item.tuple.vb  = s_tdata[47:32];
  assign in_item.tuple.lnk = s_tdata[55:48];
  assign in_item.ri        = s_tdata[63:56];

  tit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s_tvalid),
    .in_item  (in_item),
    .in_rdy   (s_tready),
    .res_vld  (res_vld),
    .res      (res),
    .res_take (res_take),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  tit_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register loads whenever it is empty or being drained
  assign res_take = res_vld && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {5'd0, res.used, res.slot.lnk, res.slot.vb, res.slot.va,
                  res.slot.flg, res.slot.cls, res.st, res.idx};
    end
  end

endmodule

`default_nettype wire

### rtl/tit_store.sv
// ----------------------------------------------------------------------------
// tit_store
// Tuple memory: one write port, one read port with registered read data.
// Entries are read only after they have been written.
// ----------------------------------------------------------------------------
`default_nettype none

module tit_store (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire [tit_pkg::IDX_W-1:0] wr_addr,
  input  tit_pkg::slot_t         wr_data,
  input  wire                    rd_en,
  input  wire [tit_pkg::IDX_W-1:0] rd_addr,
  output tit_pkg::slot_t         rd_data
);
  import tit_pkg::*;

  slot_t mem [TABLE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/tit_ctrl.sv
// ----------------------------------------------------------------------------
// tit_ctrl
// Sequencer of the intern table: decodes an item, scans the stored entries
// one per cycle through a single 56-bit equality compare, appends on a miss
// unless the table is full, and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tit_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_vld,
  input  tit_pkg::item_t           in_item,
  output logic                     in_rdy,
  output logic                     res_vld,
  output tit_pkg::res_t            res,
  input  wire                      res_take,
  output logic                     wr_en,
  output logic [tit_pkg::IDX_W-1:0] wr_addr,
  output tit_pkg::slot_t           wr_data,
  output logic                     rd_en,
  output logic [tit_pkg::IDX_W-1:0] rd_addr,
  input  tit_pkg::slot_t           rd_data
);
  import tit_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RDWAIT = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]         state, state_next;
  logic [CNT_W-1:0]   ptr, ptr_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0]   cmp_idx, cmp_idx_next;
  slot_t              tup, tup_next;
  logic [ENTRY_W-1:0] res_idx, res_idx_next;
  logic [ST_W-1:0]    res_st, res_st_next;
  slot_t              res_slot, res_slot_next;
  logic               issue;
  logic               ri_bad;

  // Read index range check against zero, fill count and depth
  assign ri_bad = (in_item.ri == 8'd0) ||
                  (32'(in_item.ri) >= 32'(count)) ||
                  (32'(in_item.ri) >= 32'(TABLE_DEPTH));

  // More entries left to fetch in the scan
  assign issue = (ptr < count);

  assign wr_data = tup;
  assign wr_addr = count[IDX_W-1:0];

  // Next-state and datapath control
  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    count_next    = count;
    cmp_vld_next  = 1'b0;
    cmp_idx_next  = ptr[IDX_W-1:0];
    tup_next      = tup;
    res_idx_next  = res_idx;
    res_st_next   = res_st;
    res_slot_next = res_slot;
    rd_en         = 1'b0;
    rd_addr       = ptr[IDX_W-1:0];
    wr_en         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_vld) begin
          tup_next      = in_item.tuple;
          res_slot_next = '0;
          if (in_item.mode == MODE_READ) begin
            if (ri_bad) begin
              res_idx_next = '0;
              res_st_next  = ST_RANGE;
              state_next   = S_RESP;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = IDX_W'(in_item.ri);
              res_idx_next = ENTRY_W'(in_item.ri);
              res_st_next  = ST_OK;
              state_next   = S_RDWAIT;
            end
          end else if (in_item.tuple.cls == 8'd0) begin
            res_idx_next = '0;
            res_st_next  = ST_CLS0;
            state_next   = S_RESP;
          end else begin
            ptr_next   = CNT_W'(1);
            state_next = S_SCAN;
          end
        end
      end
      S_RDWAIT: begin
        res_slot_next = rd_data;
        state_next    = S_RESP;
      end
      S_SCAN: begin
        // fetch one entry a cycle, compare it the cycle after
        rd_en        = issue;
        cmp_vld_next = issue;
        if (issue) begin
          ptr_next = ptr + CNT_W'(1);
        end
        priority if (cmp_vld && (rd_data == tup)) begin
          res_idx_next = ENTRY_W'(cmp_idx);
          res_st_next  = ST_OK;
          state_next   = S_RESP;
        end else if (!issue && !cmp_vld) begin
          if (count >= CNT_W'(TABLE_DEPTH)) begin
            res_idx_next = '0;
            res_st_next  = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            count_next   = count + CNT_W'(1);
            res_idx_next = ENTRY_W'(count);
            res_st_next  = ST_OK;
          end
          state_next = S_RESP;
        end else begin
          // keep scanning
          state_next = S_SCAN;
        end
      end
      S_RESP: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ptr     <= '0;
      count   <= CNT_W'(1);
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      count   <= count_next;
      cmp_vld <= cmp_vld_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tup      <= tup_next;
    cmp_idx  <= cmp_idx_next;
    res_idx  <= res_idx_next;
    res_st   <= res_st_next;
    res_slot <= res_slot_next;
  end

  assign in_rdy   = (state == S_IDLE);
  assign res_vld  = (state == S_RESP);
  assign res.idx  = res_idx;
  assign res.st   = res_st;
  assign res.slot = res_slot;
  assign res.used = USED_W'(count);

  // Checks
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + CNT_W'(1)))
    else $error("fill count did not grow on append");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count < CNT_W'(TABLE_DEPTH)))
    else $error("append into a full table");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !wr_en |=> (count == $past(count)))
    else $error("fill count changed without append");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_vld && res_st == ST_OK) |-> (res_idx != '0))
    else $error("ok result with reserved index");

  a_take_in_resp: assert property (@(posedge clk) disable iff (rst)
    res_take |-> res_vld)
    else $error("result taken while none pending");

endmodule

`default_nettype wire

### tb/sv/tuple_intern_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tuple_intern_table_top_tb
// Self-checking bench for the descriptor intern table. An in-bench copy of
// the table predicts every reply: hits on stored tuples, appends, class id
// zero rejects, full table answers and entry reads in and out of range.
// A directed opening is followed by random traffic in several flow-control
// phases, long enough to fill the table and keep working on it when full.
// ----------------------------------------------------------------------------

module tuple_intern_table_top_tb;
  import tit_pkg::*;

  // Predicted table contents and the queue of replies still owed by the DUT
  class intern_table_model;
    slot_t       entries [TABLE_DEPTH];
    int unsigned fill_count;
    res_t        owed_replies [$];
    int          errors;
    int          replies;

    function new();
      fill_count = 1;
      errors     = 0;
      replies    = 0;
    endfunction

    task report(string msg);
      $display("[%0t] reply %0d: %s", $time, replies, msg);
      errors++;
    endtask

    // Note one accepted item and queue the reply it must produce
    function void record_item(logic mode, slot_t t, logic [7:0] ri);
      res_t r;
      int   hit;
      r   = '0;
      hit = 0;
      if (mode == MODE_READ) begin
        if (ri == 8'd0 || ri >= fill_count) begin
          r.st = ST_RANGE;
        end else begin
          r.idx  = ri;
          r.st   = ST_OK;
          r.slot = entries[ri];
        end
      end else if (t.cls == 8'd0) begin
        r.st = ST_CLS0;
      end else begin
        // first stored equal tuple wins
        for (int i = 1; i < fill_count && hit == 0; i++) begin
          if (entries[IDX_W'(i)] == t) hit = i;
        end
        if (hit != 0) begin
          r.idx = ENTRY_W'(hit);
          r.st  = ST_OK;
        end else if (fill_count >= TABLE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          entries[IDX_W'(fill_count)] = t;
          r.idx = ENTRY_W'(fill_count);
          r.st  = ST_OK;
          fill_count++;
        end
      end
      r.used = USED_W'(fill_count);
      owed_replies.push_back(r);
    endfunction

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s mismatch: got %0h want %0h", name, got, want));
    endtask

    // Check one reply transfer against the oldest owed reply
    task check_reply(logic [79:0] d);
      res_t w;
      replies++;
      if (owed_replies.size() == 0) begin
        report($sformatf("unexpected reply %h", d));
      end else begin
        w = owed_replies.pop_front();
        compare_field("entry_index",        16'(d[7:0]),   16'(w.idx));
        compare_field("status",             16'(d[9:8]),   16'(w.st));
        compare_field("class_out",          16'(d[17:10]), 16'(w.slot.cls));
        compare_field("flags_out",          16'(d[25:18]), 16'(w.slot.flg));
        compare_field("first_variant_out",  d[41:26],      w.slot.va);
        compare_field("second_variant_out", d[57:42],      w.slot.vb);
        compare_field("link_out",           16'(d[65:58]), 16'(w.slot.lnk));
        compare_field("used_count",         16'(d[74:66]), 16'(w.used));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [0:0]  s_tuser = '0;    // [0] mode
  logic [63:0] s_tdata = '0;    // class_id, flag_bits, first_variant,
                                // second_variant, link_in, read_index
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;         // entry_index, status, class_out, flags_out,
                                // first_variant_out, second_variant_out,
                                // link_out, used_count, zero pad

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  intern_table_model table_model = new();

  tuple_intern_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Reply side: check each transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) table_model.check_reply(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // Offer one item, with a random idle gap first, and wait for its transfer
  task automatic send_item(logic mode, slot_t t, logic [7:0] ri);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
      // now and then a longer random gap, at times long enough to span a whole scan
      if ($urandom_range(9) == 0) repeat ($urandom_range(300)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {ri, t.lnk, t.vb, t.va, t.flg, t.cls};
    do @(posedge clk); while (!s_tready);
    table_model.record_item(mode, t, ri);
  endtask

  // Hold off the sender until every owed reply has come back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (table_model.owed_replies.size() != 0);
  endtask

  // Random item: mostly new tuples and repeats, plus near misses,
  // class id zero and reads in and out of range
  task automatic send_random();
    int          pick;
    int unsigned fill;
    slot_t       t;
    logic [7:0]  ri;
    logic        mode;
    pick  = $urandom_range(99);
    fill  = table_model.fill_count;
    t.cls = 8'($urandom_range(255, 1));
    t.flg = 8'($urandom_range(255));
    t.va  = 16'($urandom_range(65535));
    t.vb  = 16'($urandom_range(65535));
    t.lnk = 8'($urandom_range(255));
    ri    = 8'($urandom_range(255));
    mode  = MODE_INTERN;
    if (pick < 40) begin
      // fresh tuple, almost surely new
    end else if (pick < 60 && fill > 1) begin
      t = table_model.entries[IDX_W'($urandom_range(fill - 1, 1))];
    end else if (pick < 70 && fill > 1) begin
      t = table_model.entries[IDX_W'($urandom_range(fill - 1, 1))];
      t = t ^ (56'd1 << $urandom_range(55));
    end else if (pick < 75) begin
      t.cls = 8'd0;
    end else if (pick < 90 && fill > 1) begin
      mode = MODE_READ;
      ri   = 8'($urandom_range(fill - 1, 1));
    end else begin
      mode = MODE_READ;
    end
    send_item(mode, t, ri);
  endtask

  initial begin
    slot_t zero_t, ones_t, low_t;
    zero_t = '0;
    ones_t = '1;
    low_t  = '0;
    low_t.cls = 8'd1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table reads, class id zero, extremes, hits, reads
    send_item(MODE_READ,   ones_t, 8'd0);
    send_item(MODE_READ,   ones_t, 8'd1);
    send_item(MODE_INTERN, {8'd0, 48'hFFFF_FFFF_FFFF}, 8'hFF);
    send_item(MODE_INTERN, zero_t, 8'd0);
    send_item(MODE_INTERN, low_t,  8'd0);
    send_item(MODE_INTERN, ones_t, 8'hFF);
    send_item(MODE_INTERN, low_t,  8'd3);
    send_item(MODE_INTERN, ones_t, 8'd0);
    send_item(MODE_INTERN, ones_t ^ 56'd1, 8'd0);
    send_item(MODE_INTERN, ones_t ^ (56'd1 << 55), 8'd0);
    send_item(MODE_READ,   zero_t, 8'd1);
    send_item(MODE_READ,   ones_t, 8'd2);
    send_item(MODE_READ,   zero_t, 8'd3);
    send_item(MODE_READ,   zero_t, 8'd4);
    send_item(MODE_READ,   zero_t, 8'd255);
    send_item(MODE_READ,   zero_t, 8'd0);
    send_item(MODE_INTERN, ones_t ^ 56'd1, 8'd7);
    send_item(MODE_INTERN, {8'd200, 8'h5A, 16'h8001, 16'h7FFE, 8'h80}, 8'h55);
    send_item(MODE_READ,   ones_t, 8'd4);
    drain_replies();

    // Random traffic over flow-control phases; the table fills up on the way
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      repeat (163) send_random();
      drain_replies();
    end

    // Final settle: allow one full scan for any stray reply
    repeat (300) @(posedge clk);
    if (table_model.owed_replies.size() != 0)
      table_model.report($sformatf("%0d replies never arrived",
                                   table_model.owed_replies.size()));
    if (table_model.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tit_pkg.sv
rtl/tit_store.sv
rtl/tit_ctrl.sv
rtl/tuple_intern_table_top.sv
tb/sv/tuple_intern_table_top_tb.sv
